/* rtl/core/remainder_range_sum_macros.svh */
// Assertion helpers used by the block's control module.
// Each expects aclk and aresetn in the scope of the module that uses it.
`ifndef REMAINDER_RANGE_SUM_MACROS_SVH
`define REMAINDER_RANGE_SUM_MACROS_SVH

// Same-cycle implication.
`define RRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rrs_pkg.sv */
package rrs_pkg;

    // Bits of the dividend and range bounds that take part in the sum.
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = VALUE_BITS + 1;
    localparam int ACC_W      = 2 * VALUE_BITS;
    localparam int PROD_W     = VALUE_BITS + IDX_W;
    localparam int DIV_CNT_W  = $clog2(VALUE_BITS);

    // Fixed field widths of the channels.
    localparam int FIELD_W    = 32;
    localparam int SUM_W      = 64;
    localparam int IN_DATA_W  = 2 * FIELD_W;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // Register index, taken from paddr[2].
    localparam logic REG_DIVIDEND = 1'b0;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_Q,
        OP_CAP_Q,
        OP_DIV_END,
        OP_CAP_END,
        OP_CAP_B,
        OP_SET_TERM,
        OP_ACC_NEXT,
        OP_SET_TAIL,
        OP_ACC_TAIL,
        OP_RESULT
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic bad;
        logic more;
        logic tail;
    } dp_sts_t;

endpackage

/* rtl/core/remainder_range_sum.sv */
// Sum of remainders of the configured dividend P over a divisor range.
// Write P through the APB port (register dividend at byte address 0) while
// the block is idle; reads return the stored value, pready is always high.
// Each request on the s_ channel carries range_low and range_high; one
// result per request leaves on the m_ channel with the exact 64-bit sum of
// P mod i for low <= i <= high, and m_tuser flags a rejected range (low of
// zero or low above high), which then carries a sum of zero.
// The range is walked in runs of equal quotient P / i. Each run costs two
// passes through the shared radix-2 divider plus control and multiply steps.
// A request takes one such run for each of the R runs inside min(high, P),
// R being at most about 2*sqrt(P). Indices above P take one extra multiply.
// One request is in work at a time; s_tready is high once the previous
// result has moved into the output register, even while that result still
// waits for m_tready. A stalled receiver holds the result and, once the next
// request is done, holds that one in the controller until the slot frees.
// Reset (aresetn low, synchronous) clears P, drops any request in work and
// empties the output register.
module remainder_range_sum
    import rrs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: range_low [31:0], range_high [63:32]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // m_tdata: remainder_sum [63:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SUM_W-1:0]      m_tdata,
    // m_tuser: bad_range [0]
    output logic [0:0]            m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CFG_DATA_W-1:0] dividend_reg, dividend_next;
    logic                  cfg_write;
    dp_cmd_t               cmd;
    dp_sts_t               sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        dividend_next = dividend_reg;
        if (cfg_write && (paddr[2] == REG_DIVIDEND)) begin
            dividend_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dividend_reg <= '0;
        end else begin
            dividend_reg <= dividend_next;
        end
    end

    assign prdata = (paddr[2] == REG_DIVIDEND) ? dividend_reg : '0;

    rrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rrs_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .dividend      (dividend_reg),
        .range_low     (s_tdata[FIELD_W-1:0]),
        .range_high    (s_tdata[IN_DATA_W-1:FIELD_W]),
        .remainder_sum (m_tdata),
        .bad_range     (m_tuser[0])
    );

endmodule

/* rtl/core/rrs_div.sv */
module rrs_div
    import rrs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] num,
    input  logic [VALUE_BITS-1:0] den,
    output logic                  busy,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quot,
    output logic [VALUE_BITS-1:0] rem
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] num_reg, num_next;
    logic [VALUE_BITS-1:0] den_reg, den_next;
    logic [VALUE_BITS:0]   rem_reg, rem_next;

    logic [VALUE_BITS:0]   shifted;
    logic [VALUE_BITS:0]   trial;
    logic                  fits;

    // One quotient bit per cycle, restoring form.
    assign shifted = {rem_reg[VALUE_BITS-1:0], num_reg[VALUE_BITS-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = fits ? trial : shifted;
            num_next = {num_reg[VALUE_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(VALUE_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = num_reg;
    assign rem  = rem_reg[VALUE_BITS-1:0];

endmodule

/* rtl/core/rrs_datapath.sv */
module rrs_datapath
    import rrs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts,
    input  logic [CFG_DATA_W-1:0] dividend,
    input  logic [FIELD_W-1:0]    range_low,
    input  logic [FIELD_W-1:0]    range_high,
    output logic [SUM_W-1:0]      remainder_sum,
    output logic                  bad_range
);

    logic [VALUE_BITS-1:0] p_reg, p_next;
    logic [VALUE_BITS-1:0] lo_reg, lo_next;
    logic [VALUE_BITS-1:0] hi_reg, hi_next;
    logic [VALUE_BITS-1:0] top_reg, top_next;
    logic [IDX_W-1:0]      i_reg, i_next;
    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [VALUE_BITS-1:0] end_reg, end_next;
    logic [VALUE_BITS-1:0] a_reg, a_next;
    logic [VALUE_BITS-1:0] b_reg, b_next;
    logic [VALUE_BITS-1:0] mul_x_reg, mul_x_next;
    logic [IDX_W-1:0]      mul_y_reg, mul_y_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [SUM_W-1:0]      sum_out_reg, sum_out_next;
    logic                  bad_out_reg, bad_out_next;

    logic [VALUE_BITS-1:0] p_in, lo_in, hi_in;
    logic [VALUE_BITS-1:0] end_sel;
    logic [IDX_W-1:0]      run_cnt, run_sum;
    logic [IDX_W-1:0]      tail_start, tail_cnt;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_den;
    logic                  div_busy, div_done;
    logic [VALUE_BITS-1:0] div_quot, div_rem;

    assign p_in  = dividend[VALUE_BITS-1:0];
    assign lo_in = range_low[VALUE_BITS-1:0];
    assign hi_in = range_high[VALUE_BITS-1:0];

    assign div_start = (cmd.op == OP_DIV_Q) || (cmd.op == OP_DIV_END);
    assign div_den   = (cmd.op == OP_DIV_Q) ? i_reg[VALUE_BITS-1:0] : q_reg;

    rrs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (p_reg),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    // Last index of the current quotient run, clipped to the range.
    assign end_sel    = (div_quot > top_reg) ? top_reg : div_quot;
    assign run_cnt    = {1'b0, end_reg} - i_reg + 1'b1;
    assign run_sum    = {1'b0, a_reg} + {1'b0, b_reg};
    // Indices past the dividend each add the dividend itself.
    assign tail_start = (lo_reg > p_reg) ? {1'b0, lo_reg} : {1'b0, p_reg} + 1'b1;
    assign tail_cnt   = {1'b0, hi_reg} - tail_start + 1'b1;

    always_comb begin
        p_next       = p_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        top_next     = top_reg;
        i_next       = i_reg;
        q_next       = q_reg;
        end_next     = end_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        mul_x_next   = mul_x_reg;
        mul_y_next   = mul_y_reg;
        acc_next     = acc_reg;
        sum_out_next = sum_out_reg;
        bad_out_next = bad_out_reg;
        prod_next    = PROD_W'(mul_x_reg) * PROD_W'(mul_y_reg);
        unique case (cmd.op)
            OP_LOAD: begin
                p_next   = p_in;
                lo_next  = lo_in;
                hi_next  = hi_in;
                top_next = (hi_in < p_in) ? hi_in : p_in;
                i_next   = {1'b0, lo_in};
                acc_next = '0;
            end
            OP_CAP_Q: begin
                q_next = div_quot;
                a_next = div_rem;
            end
            OP_CAP_END: begin
                end_next   = end_sel;
                mul_x_next = q_reg;
                mul_y_next = {1'b0, end_sel};
            end
            OP_CAP_B: begin
                b_next = p_reg - prod_reg[VALUE_BITS-1:0];
            end
            OP_SET_TERM: begin
                // Halve whichever factor is even so the product stays exact.
                if (run_cnt[0]) begin
                    mul_x_next = run_cnt[VALUE_BITS-1:0];
                    mul_y_next = {1'b0, run_sum[IDX_W-1:1]};
                end else begin
                    mul_x_next = run_cnt[IDX_W-1:1];
                    mul_y_next = run_sum;
                end
            end
            OP_ACC_NEXT: begin
                acc_next = acc_reg + prod_reg[ACC_W-1:0];
                i_next   = {1'b0, end_reg} + 1'b1;
            end
            OP_SET_TAIL: begin
                mul_x_next = p_reg;
                mul_y_next = tail_cnt;
            end
            OP_ACC_TAIL: begin
                acc_next = acc_reg + prod_reg[ACC_W-1:0];
            end
            OP_RESULT: begin
                sum_out_next = SUM_W'(acc_reg);
                bad_out_next = sts.bad;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        p_reg       <= p_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        top_reg     <= top_next;
        i_reg       <= i_next;
        q_reg       <= q_next;
        end_reg     <= end_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        mul_x_reg   <= mul_x_next;
        mul_y_reg   <= mul_y_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        sum_out_reg <= sum_out_next;
        bad_out_reg <= bad_out_next;
    end

    assign sts.div_busy = div_busy;
    assign sts.div_done = div_done;
    assign sts.bad      = (lo_reg == '0) || (lo_reg > hi_reg);
    assign sts.more     = i_reg <= {1'b0, top_reg};
    assign sts.tail     = hi_reg > p_reg;

    assign remainder_sum = sum_out_reg;
    assign bad_range     = bad_out_reg;

endmodule

/* rtl/core/rrs_ctrl.sv */
`include "remainder_range_sum_macros.svh"

module rrs_ctrl
    import rrs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVQ,
        ST_WAITQ,
        ST_DIVE,
        ST_WAITE,
        ST_MULB,
        ST_CAPB,
        ST_TERM,
        ST_MULT,
        ST_ACC,
        ST_TAIL,
        ST_TAILW,
        ST_TACC,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   div_issue;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd.op       = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.bad) begin
                    state_next = ST_DONE;
                end else if (sts.more) begin
                    state_next = ST_DIVQ;
                end else if (sts.tail) begin
                    state_next = ST_TAIL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIVQ: begin
                cmd.op     = OP_DIV_Q;
                state_next = ST_WAITQ;
            end
            ST_WAITQ: begin
                if (sts.div_done) begin
                    cmd.op     = OP_CAP_Q;
                    state_next = ST_DIVE;
                end
            end
            ST_DIVE: begin
                cmd.op     = OP_DIV_END;
                state_next = ST_WAITE;
            end
            ST_WAITE: begin
                if (sts.div_done) begin
                    cmd.op     = OP_CAP_END;
                    state_next = ST_MULB;
                end
            end
            ST_MULB: begin
                state_next = ST_CAPB;
            end
            ST_CAPB: begin
                cmd.op     = OP_CAP_B;
                state_next = ST_TERM;
            end
            ST_TERM: begin
                cmd.op     = OP_SET_TERM;
                state_next = ST_MULT;
            end
            ST_MULT: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.op     = OP_ACC_NEXT;
                state_next = ST_CHECK;
            end
            ST_TAIL: begin
                cmd.op     = OP_SET_TAIL;
                state_next = ST_TAILW;
            end
            ST_TAILW: begin
                state_next = ST_TACC;
            end
            ST_TACC: begin
                cmd.op     = OP_ACC_TAIL;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the output register is free or drains this cycle.
                if (!m_valid_reg || m_tready) begin
                    cmd.op       = OP_RESULT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign div_issue = (cmd.op == OP_DIV_Q) || (cmd.op == OP_DIV_END);

    `RRS_ASSERT_IMP(a_div_free, div_issue, !sts.div_busy, "divide issued while divider busy")
    `RRS_ASSERT_NXT(a_div_no_early, div_issue, !sts.div_done, "divider done right after start")
    `RRS_ASSERT_NXT(a_load_check, s_tvalid && s_tready, state_reg == ST_CHECK, "load skipped")
    `RRS_ASSERT_IMP(a_result_slot, cmd.op == OP_RESULT, !m_tvalid || m_tready, "result lost")

endmodule

/* tb/remainder_range_sum_test.sv */
`timescale 1ns / 100ps

module remainder_range_sum_test;
    import rrs_pkg::*;

    typedef struct {
        bit [SUM_W-1:0] sum;
        bit             bad;
    } range_result_t;

    localparam logic [CFG_ADDR_W-1:0] DIVIDEND_ADDR = {REG_DIVIDEND, 2'b00};
    localparam bit [FIELD_W-1:0]      FIELD_MAX     = '1;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [SUM_W-1:0]      m_tdata;
    logic [0:0]            m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    bit [CFG_DATA_W-1:0] dividend_copy;
    range_result_t       pending_sums[$];
    int                  mismatches;
    bit                  idling;
    int                  hold_cycles;

    remainder_range_sum dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Walk the range in runs of equal quotient, indices above P add P each.
    function automatic range_result_t predict_range_sum(bit [FIELD_W-1:0] low_in,
                                                        bit [FIELD_W-1:0] high_in);
        bit [63:0]     mask;
        bit [63:0]     p, lo, hi, top, i, q, stop, cnt, s, start;
        range_result_t r;
        mask  = (64'd1 << VALUE_BITS) - 64'd1;
        p     = {32'd0, dividend_copy} & mask;
        lo    = {32'd0, low_in} & mask;
        hi    = {32'd0, high_in} & mask;
        r.sum = '0;
        r.bad = 1'b0;
        if (lo == 0 || lo > hi) begin
            r.bad = 1'b1;
            return r;
        end
        top = (hi < p) ? hi : p;
        i   = lo;
        while (i <= top) begin
            q    = p / i;
            stop = p / q;
            if (stop > top) stop = top;
            cnt  = stop - i + 1;
            s    = (p - q * i) + (p - q * stop);
            // remainders fall by q across the run: arithmetic series
            r.sum += cnt[0] ? cnt * (s >> 1) : (cnt >> 1) * s;
            i = stop + 1;
        end
        if (hi > p) begin
            start = (lo > p) ? lo : p + 1;
            r.sum += (hi - start + 1) * p;
        end
        return r;
    endfunction

    task automatic note_mismatch(string field, bit [63:0] want, bit [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $time, field, want, got);
    endtask

    task automatic set_dividend(bit [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DIVIDEND_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        dividend_copy = value;
    endtask

    task automatic send_range(bit [FIELD_W-1:0] lo, bit [FIELD_W-1:0] hi);
        int gap;
        gap = idling ? $urandom_range(19, 0) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hi, lo};
        do @(posedge aclk); while (!s_tready);
        pending_sums.push_back(predict_range_sum(lo, hi));
    endtask

    // Drop valid and hold until every queued sum is back.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Pick a range whose run count stays small for the current dividend.
    task automatic draw_range(output bit [FIELD_W-1:0] lo, output bit [FIELD_W-1:0] hi);
        int        pick;
        bit [63:0] sum_hi;
        pick = $urandom_range(99, 0);
        if (pick > 79 && dividend_copy > 4096) pick = 50;
        if (pick < 5) begin
            lo = '0;
            hi = $urandom;
        end else if (pick < 10) begin
            hi = $urandom_range(FIELD_MAX - 1, 0);
            lo = $urandom_range(FIELD_MAX, hi + 1);
        end else if (pick < 45) begin
            lo = $urandom_range(1, 0) ? $urandom_range(dividend_copy, 1) : $urandom;
            if (lo == 0) lo = 1;
            sum_hi = {32'd0, lo} + $urandom_range(40, 0);
            hi = (sum_hi > FIELD_MAX) ? FIELD_MAX : sum_hi[FIELD_W-1:0];
        end else if (pick < 80) begin
            // above P/32 the quotient stays below 32
            lo = $urandom_range(FIELD_MAX, dividend_copy / 32 + 1);
            hi = $urandom_range(FIELD_MAX, lo);
        end else begin
            lo = $urandom_range(64, 1);
            hi = $urandom_range(FIELD_MAX, lo);
        end
    endtask

    task automatic test_reset_dividend;
        send_range(1, FIELD_MAX);
        send_range(5, 5);
        drain();
    endtask

    task automatic test_rejected_ranges;
        send_range(0, 0);
        send_range(0, FIELD_MAX);
        send_range(FIELD_MAX, FIELD_MAX - 1);
        send_range(2, 1);
        drain();
    endtask

    task automatic test_fixed_dividends;
        set_dividend(1000);
        send_range(1, 1000);
        send_range(1, FIELD_MAX);
        send_range(1, 1);
        send_range(999, 1001);
        send_range(1001, FIELD_MAX);
        drain();
        set_dividend(FIELD_MAX);
        send_range(1, 40);
        send_range(FIELD_MAX, FIELD_MAX);
        send_range(32'h8000_0000, FIELD_MAX);
        send_range(FIELD_MAX - 40, FIELD_MAX);
        drain();
        set_dividend(32'h8000_0000);
        send_range(32'h8000_0001, FIELD_MAX);
        send_range(1, 1);
        send_range(32'h4000_0000, 32'h8000_0000);
        drain();
        set_dividend(1);
        send_range(1, 1);
        send_range(1, 2);
        drain();
        set_dividend(0);
        send_range(3, 7);
        drain();
    endtask

    // Hold the receiver off long enough that the block backs up into s_tready.
    task automatic test_input_stall;
        bit [FIELD_W-1:0] idx;
        set_dividend(12345);
        idling      = 1'b0;
        hold_cycles = 1500;
        repeat (8) begin
            idx = $urandom_range(12345, 1);
            send_range(idx, idx);
        end
        drain();
        idling = 1'b1;
    endtask

    task automatic test_random_ranges;
        bit [FIELD_W-1:0] lo, hi;
        int               phase;
        int               count;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_dividend($urandom_range(4096, 1));
                1: set_dividend($urandom);
                2: set_dividend($urandom >> $urandom_range(20, 1));
                default: set_dividend($urandom);
            endcase
            idling = (phase != 2);
            count  = (phase == 2) ? 35 : 38;
            repeat (count) begin
                draw_range(lo, hi);
                send_range(lo, hi);
            end
            drain();
        end
        idling = 1'b1;
    endtask

    // Result side: random stalls, plus the long hold when one is requested.
    initial begin
        int gap;
        m_tready = 1'b0;
        forever begin
            if (hold_cycles > 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
            end else begin
                gap = idling ? $urandom_range(19, 0) : 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_tvalid && m_tready));
        end
    end

    initial begin
        range_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_sums.size() == 0) begin
                    note_mismatch("unexpected result", '0, m_tdata);
                end else begin
                    want = pending_sums.pop_front();
                    if (m_tdata !== want.sum)
                        note_mismatch("remainder_sum", want.sum, m_tdata);
                    if (m_tuser[0] !== want.bad)
                        note_mismatch("bad_range", want.bad, m_tuser[0]);
                end
            end
        end
    end

    initial begin
        #100_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        dividend_copy = '0;
        mismatches    = 0;
        idling        = 1'b1;
        hold_cycles   = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_dividend();
        test_rejected_ranges();
        test_fixed_dividends();
        test_input_stall();
        test_random_ranges();

        repeat (100) @(posedge aclk);
        if (mismatches == 0 && pending_sums.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
